// ===== rtl/core/nna_pkg.sv =====
package nna_pkg;

    localparam int unsigned FuncW = 4;
    localparam int unsigned DataW = 16;
    localparam int unsigned WidthDefault = 16;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [3:0] {
        OP_ISZERO  = 4'd0,
        OP_SUCC    = 4'd1,
        OP_ADD     = 4'd2,
        OP_EQUAL   = 4'd3,
        OP_GREATER = 4'd4,
        OP_SUB     = 4'd5,
        OP_MUL     = 4'd6,
        OP_DIV     = 4'd7,
        OP_MOD     = 4'd8
    } op_t;

    // operation class chosen by the front end
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_LOGIC = 2'd1,
        CLS_MUL   = 2'd2,
        CLS_DIV   = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [FuncW-1:0] func;
        logic [DataW-1:0] x;
        logic [DataW-1:0] y;
    } cmd_t;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             error;
        logic             overflow;
    } res_t;

endpackage

// ===== rtl/core/nna_front.sv =====
module nna_front #(
    parameter int unsigned WIDTH = nna_pkg::WidthDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nna_pkg::FuncW-1:0]     in_func,
    input  logic [nna_pkg::DataW-1:0]     in_x,
    input  logic [nna_pkg::DataW-1:0]     in_y,
    output logic                          q_valid,
    input  logic                          q_ready,
    output nna_pkg::cmd_t                 q_cmd
);

    localparam int unsigned Depth = nna_pkg::QueueDepth;
    localparam int unsigned AW = $clog2(Depth);
    localparam int unsigned EffW = (WIDTH < nna_pkg::DataW) ? WIDTH : nna_pkg::DataW;

    nna_pkg::cmd_t mem_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    nna_pkg::cmd_t cmd;
    logic [nna_pkg::DataW-1:0] mask;
    logic push, pop;

    assign mask = nna_pkg::DataW'({EffW{1'b1}});

    always_comb begin
        cmd.func = in_func;
        cmd.x = in_x & mask;
        cmd.y = in_y & mask;
        case (nna_pkg::op_t'(in_func))
            nna_pkg::OP_ISZERO, nna_pkg::OP_SUCC, nna_pkg::OP_ADD, nna_pkg::OP_EQUAL,
            nna_pkg::OP_GREATER, nna_pkg::OP_SUB: cmd.cls = nna_pkg::CLS_LOGIC;
            nna_pkg::OP_MUL: cmd.cls = nna_pkg::CLS_MUL;
            nna_pkg::OP_DIV, nna_pkg::OP_MOD: cmd.cls = nna_pkg::CLS_DIV;
            default: cmd.cls = nna_pkg::CLS_NONE;
        endcase
    end

    assign in_ready = (count_reg != (AW+1)'(Depth));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/nna_back.sv =====
module nna_back #(
    parameter int unsigned WIDTH = nna_pkg::WidthDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  nna_pkg::cmd_t q_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output nna_pkg::res_t out_res
);

    localparam int unsigned DW = nna_pkg::DataW;
    localparam int unsigned EffW = (WIDTH < DW) ? WIDTH : DW;
    // stages 1 to DW each resolve one restoring-division bit; stage 0 is the issue register
    localparam int unsigned NS = DW + 1;

    logic [DW-1:0] mask;
    assign mask = DW'({EffW{1'b1}});

    logic                   v_reg    [NS+1];
    nna_pkg::cls_t          cls_reg  [NS+1];
    logic [nna_pkg::FuncW-1:0] func_reg [NS+1];
    logic [DW-1:0]          quo_reg  [NS+1];
    logic [DW:0]            rem_reg  [NS+1];
    logic [DW-1:0]          dvs_reg  [NS+1];
    nna_pkg::res_t          res_reg  [NS+1];

    logic advance;
    logic                  out_v_reg;
    nna_pkg::res_t         out_res_reg;
    nna_pkg::res_t         out_res_next;

    assign advance   = !out_v_reg || out_ready;
    assign q_ready   = advance;
    assign out_valid = out_v_reg;
    assign out_res   = out_res_reg;

    // issue stage: simple ops resolved, mul product registered, divider seeded
    nna_pkg::res_t simple;
    logic [DW:0]   sum;
    logic [2*DW-1:0] prod;
    always_comb begin
        simple = '0;
        sum = {1'b0, q_cmd.x} + {1'b0, (q_cmd.func == nna_pkg::OP_SUCC) ? DW'(1) : q_cmd.y};
        prod = q_cmd.x * q_cmd.y;
        case (nna_pkg::op_t'(q_cmd.func))
            nna_pkg::OP_ISZERO:  simple.value = DW'(q_cmd.x == '0);
            nna_pkg::OP_SUCC, nna_pkg::OP_ADD: begin
                simple.value = sum[DW-1:0] & mask;
                simple.overflow = (sum & ~{1'b0, mask}) != '0;
            end
            nna_pkg::OP_EQUAL:   simple.value = DW'(q_cmd.x == q_cmd.y);
            nna_pkg::OP_GREATER: simple.value = DW'(q_cmd.x > q_cmd.y);
            nna_pkg::OP_SUB: begin
                if (q_cmd.y > q_cmd.x) simple.error = 1'b1;
                else simple.value = q_cmd.x - q_cmd.y;
            end
            nna_pkg::OP_MUL: begin
                simple.value = prod[DW-1:0] & mask;
                simple.overflow = (prod & ~{{DW{1'b0}}, mask}) != '0;
            end
            nna_pkg::OP_DIV, nna_pkg::OP_MOD: simple.error = (q_cmd.y == '0);
            default: simple = '0;
        endcase
    end

    // divider result replaces the value unless the divisor was zero
    always_comb begin
        out_res_next = res_reg[NS];
        if (cls_reg[NS] == nna_pkg::CLS_DIV && !res_reg[NS].error) begin
            out_res_next.value = (func_reg[NS] == nna_pkg::OP_DIV)
                                 ? quo_reg[NS] : rem_reg[NS][DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NS; i++) v_reg[i] <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= q_valid;
            for (int i = 1; i <= NS; i++) v_reg[i] <= v_reg[i-1];
            out_v_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cls_reg[0]  <= q_cmd.cls;
            func_reg[0] <= q_cmd.func;
            quo_reg[0]  <= q_cmd.x;
            rem_reg[0]  <= '0;
            dvs_reg[0]  <= q_cmd.y;
            res_reg[0]  <= simple;
            for (int i = 1; i <= NS; i++) begin
                cls_reg[i]  <= cls_reg[i-1];
                func_reg[i] <= func_reg[i-1];
                dvs_reg[i]  <= dvs_reg[i-1];
                res_reg[i]  <= res_reg[i-1];
                if (i <= DW) begin
                    // shift next dividend bit in, try subtract
                    if ({rem_reg[i-1][DW-1:0], quo_reg[i-1][DW-1]} >= {1'b0, dvs_reg[i-1]}) begin
                        rem_reg[i] <= {rem_reg[i-1][DW-1:0], quo_reg[i-1][DW-1]}
                                      - {1'b0, dvs_reg[i-1]};
                        quo_reg[i] <= {quo_reg[i-1][DW-2:0], 1'b1};
                    end else begin
                        rem_reg[i] <= {rem_reg[i-1][DW-1:0], quo_reg[i-1][DW-1]};
                        quo_reg[i] <= {quo_reg[i-1][DW-2:0], 1'b0};
                    end
                end else begin
                    rem_reg[i] <= rem_reg[i-1];
                    quo_reg[i] <= quo_reg[i-1];
                end
            end
            out_res_reg <= out_res_next;
        end
    end

endmodule

// ===== rtl/core/natural_number_alu.sv =====
// Unsigned integer ALU: is-zero, successor, add, equal, greater, subtract,
// multiply, divide and modulo on WIDTH-bit naturals (WIDTH up to 16 takes
// effect; operands are masked to it). One transaction is accepted per cycle
// while the command queue has room, and results come out in order through
// a 4-entry command queue, an issue register, a 16-stage restoring divider
// pipeline that every operation passes through, a final alignment stage and
// the output register. Sub underflow and a zero divisor give value 0 with
// error set; succ, add and mul that exceed WIDTH give the truncated value
// with overflow set; unused codes give all zeros.
module natural_number_alu #(
    parameter int unsigned WIDTH = nna_pkg::WidthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[3:0], x[19:4], y[35:20], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // value[15:0], error[16], overflow[17], zero pad
);

    logic          q_valid, q_ready;
    nna_pkg::cmd_t q_cmd;
    nna_pkg::res_t res;

    nna_front #(.WIDTH(WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tdata[3:0]),
        .in_x     (s_tdata[19:4]),
        .in_y     (s_tdata[35:20]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    nna_back #(.WIDTH(WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.overflow, res.error, res.value};

endmodule

// ===== rtl/core/nna_checker.sv =====
module nna_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("error and overflow both set");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("error result not zero");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("pad bits set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind natural_number_alu nna_checker u_nna_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
